// ===== rtl/gfa_pkg.sv =====
`timescale 1ns / 1ps
package gfa_pkg;

    localparam int unsigned OFF_W  = 33;
    localparam int unsigned D2_W   = 66;
    localparam int unsigned MG_W   = 64;
    localparam int unsigned K_W    = 96;
    localparam int unsigned NUM_W  = 113;
    localparam int unsigned F_W    = 80;
    localparam int unsigned ROOT_W = 34;
    localparam int unsigned SREM_W = 36;
    localparam int unsigned SUM_W  = 48;
    localparam int unsigned TERM_W = 49;
    localparam int unsigned CNT_W  = 7;

    localparam logic [CNT_W-1:0] SQ_LAST   = 7'd32;
    localparam logic [CNT_W-1:0] ROOT_LAST = 7'd33;
    localparam logic [CNT_W-1:0] MUL_LAST  = 7'd32;
    localparam logic [CNT_W-1:0] DIV_LAST  = 7'd112;

    localparam logic [31:0] GRAVITY_RESET = 32'h0001_0000;
    localparam logic [31:0] TSTEP_RESET   = 32'h0001_0000;

    localparam logic REG_GRAVITY = 1'b0;
    localparam logic REG_TSTEP   = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_CHK,
        S_ROOT,
        S_DIV,
        S_DIVEND,
        S_AMUL,
        S_FIN
    } t_state;

endpackage

// ===== rtl/gravity_force_accumulator_core.sv =====
`timescale 1ns / 1ps
// An item that adds a force passes through the squaring, the square root, the three
// 113-step bit-serial divisions and the 33-step shift-add multiplies; an item
// skipped at zero distance or overlap ends after the squaring. A new item is
// accepted only in idle, once the previous one is finished.
// Reset (synchronous, active low): registers return to 1.0, sums and clip flag
// clear, no result pending.
module gravity_force_accumulator_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic          i_cfg_addr,
    input  logic [31:0]   i_cfg_wr_data,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // source_x, source_y, source_mass, source_radius, target_x, target_y, target_radius
    input  logic [223:0]  i_s_tdata,
    // has_body
    input  logic          i_s_tuser,
    input  logic          i_s_tlast,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // accel_x, accel_y
    output logic [95:0]   o_m_tdata,
    // saturated
    output logic          o_m_tuser
);
    import gfa_pkg::*;

    t_state r_state, n_state;

    logic [31:0]        r_gc, r_dt;
    logic [OFF_W-1:0]   r_adx, r_ady, r_rsum;
    logic               r_sx, r_sy, r_body, r_last;
    logic [31:0]        r_mass;
    logic [OFF_W-1:0]   r_sa, r_sb, r_sc, r_sd;
    logic [D2_W-1:0]    r_d2, r_r2, r_dvs, r_rem;
    logic [MG_W-1:0]    r_mg;
    logic [K_W-1:0]     r_k;
    logic [NUM_W-1:0]   r_num;
    logic [SREM_W-1:0]  r_srem;
    logic [ROOT_W-1:0]  r_root;
    logic [F_W-1:0]     r_q, r_f;
    logic               r_qo, r_tdiv, r_axis;
    logic [CNT_W-1:0]   r_cnt;
    logic signed [SUM_W-1:0] r_sum_x, r_sum_y;
    logic               r_clip;
    logic               r_m_valid, r_m_user;
    logic [95:0]        r_m_data;

    logic signed [32:0] dx, dy;
    logic [OFF_W-1:0]   adx_in, ady_in, rsum_in;
    logic               s_fire, out_free, emit, skip;
    logic [D2_W-1:0]    sq_d2, sq_r2;
    logic [MG_W-1:0]    sq_mg;
    logic [37:0]        srem_sh, trial, srem_diff;
    logic               s_ge;
    logic [K_W-1:0]     k_next;
    logic [D2_W:0]      rem2, rdiff;
    logic               d_ge;
    logic [NUM_W-1:0]   mul_next;
    logic [TERM_W-1:0]  tq, term;
    logic signed [SUM_W+1:0] acc_cur, acc_s, acc_lim;
    logic               acc_clip;

    assign s_fire   = i_s_tvalid && o_s_tready;
    assign out_free = !r_m_valid || i_m_tready;
    assign emit     = (r_state == S_FIN) && r_last && out_free;

    assign dx = $signed({i_s_tdata[31], i_s_tdata[31:0]})
              - $signed({i_s_tdata[159], i_s_tdata[159:128]});
    assign dy = $signed({i_s_tdata[63], i_s_tdata[63:32]})
              - $signed({i_s_tdata[191], i_s_tdata[191:160]});
    assign adx_in  = dx[32] ? OFF_W'(-dx) : OFF_W'(dx);
    assign ady_in  = dy[32] ? OFF_W'(-dy) : OFF_W'(dy);
    assign rsum_in = {1'b0, i_s_tdata[127:96]} + {1'b0, i_s_tdata[223:192]};

    assign sq_d2 = {r_d2[D2_W-2:0], 1'b0}
                 + (r_sa[OFF_W-1] ? {33'd0, r_adx} : {D2_W{1'b0}})
                 + (r_sb[OFF_W-1] ? {33'd0, r_ady} : {D2_W{1'b0}});
    assign sq_r2 = {r_r2[D2_W-2:0], 1'b0}
                 + (r_sc[OFF_W-1] ? {33'd0, r_rsum} : {D2_W{1'b0}});
    assign sq_mg = {r_mg[MG_W-2:0], 1'b0}
                 + (r_sd[OFF_W-1] ? {32'd0, r_mass} : {MG_W{1'b0}});

    assign skip = (r_d2 == '0) || (r_body && (r_r2 >= r_d2));

    assign srem_sh   = {r_srem, r_num[NUM_W-1 -: 2]};
    assign trial     = {2'b00, r_root, 2'b01};
    assign s_ge      = srem_sh >= trial;
    assign srem_diff = srem_sh - trial;
    assign k_next    = {r_k[K_W-2:0], 1'b0}
                     + (r_sd[OFF_W-1] ? {32'd0, r_mg} : {K_W{1'b0}});

    assign rem2  = {r_rem, r_num[NUM_W-1]};
    assign d_ge  = rem2 >= {1'b0, r_dvs};
    assign rdiff = rem2 - {1'b0, r_dvs};

    assign mul_next = {r_num[NUM_W-2:0], 1'b0}
                    + (r_sa[OFF_W-1] ? {33'd0, r_f} : {NUM_W{1'b0}});

    assign tq   = r_q[56:8];
    assign term = (r_qo || (|r_q[F_W-1:57]) || (tq > {1'b1, 48'd0})) ? {1'b1, 48'd0} : tq;

    always_comb begin
        acc_cur = r_axis ? {{2{r_sum_y[SUM_W-1]}}, r_sum_y}
                         : {{2{r_sum_x[SUM_W-1]}}, r_sum_x};
        if (r_axis ? r_sy : r_sx) begin
            acc_s = acc_cur - $signed({1'b0, term});
        end else begin
            acc_s = acc_cur + $signed({1'b0, term});
        end
        acc_clip = 1'b0;
        acc_lim  = acc_s;
        if (acc_s > $signed({2'b00, 1'b0, {(SUM_W-1){1'b1}}})) begin
            acc_lim  = {2'b00, 1'b0, {(SUM_W-1){1'b1}}};
            acc_clip = 1'b1;
        end else if (acc_s < $signed({2'b11, 1'b1, {(SUM_W-1){1'b0}}})) begin
            acc_lim  = {2'b11, 1'b1, {(SUM_W-1){1'b0}}};
            acc_clip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) n_state = S_SQ;
            end
            S_SQ:     if (r_cnt == SQ_LAST) n_state = S_CHK;
            S_CHK:    n_state = skip ? S_FIN : S_ROOT;
            S_ROOT:   if (r_cnt == ROOT_LAST) n_state = S_DIV;
            S_DIV:    if (r_cnt == DIV_LAST) n_state = S_DIVEND;
            S_DIVEND: n_state = (r_tdiv && r_axis) ? S_FIN : S_AMUL;
            S_AMUL:   if (r_cnt == MUL_LAST) n_state = S_DIV;
            S_FIN:    if (!r_last || out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gc <= GRAVITY_RESET;
            r_dt <= TSTEP_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                REG_GRAVITY: r_gc <= i_cfg_wr_data;
                REG_TSTEP:   r_dt <= i_cfg_wr_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_x   <= '0;
            r_sum_y   <= '0;
            r_clip    <= 1'b0;
            r_m_valid <= 1'b0;
            r_cnt     <= '0;
            r_tdiv    <= 1'b0;
            r_axis    <= 1'b0;
        end else begin
            r_cnt <= r_cnt + 1'b1;
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (s_fire) begin
                        r_adx  <= adx_in;
                        r_ady  <= ady_in;
                        r_rsum <= rsum_in;
                        r_sx   <= dx[32];
                        r_sy   <= dy[32];
                        r_mass <= i_s_tdata[95:64];
                        r_body <= i_s_tuser;
                        r_last <= i_s_tlast;
                        r_sa   <= adx_in;
                        r_sb   <= ady_in;
                        r_sc   <= rsum_in;
                        r_sd   <= {1'b0, r_gc};
                        r_d2   <= '0;
                        r_r2   <= '0;
                        r_mg   <= '0;
                    end
                end
                S_SQ: begin
                    r_d2 <= sq_d2;
                    r_r2 <= sq_r2;
                    r_mg <= sq_mg;
                    r_sa <= r_sa << 1;
                    r_sb <= r_sb << 1;
                    r_sc <= r_sc << 1;
                    r_sd <= r_sd << 1;
                end
                S_CHK: begin
                    r_cnt  <= '0;
                    r_num  <= {2'b00, r_d2, 45'd0};
                    r_srem <= '0;
                    r_root <= '0;
                    r_k    <= '0;
                    r_sd   <= {1'b0, r_dt};
                end
                S_ROOT: begin
                    r_srem <= s_ge ? srem_diff[SREM_W-1:0] : srem_sh[SREM_W-1:0];
                    r_root <= {r_root[ROOT_W-2:0], s_ge};
                    r_num  <= r_num << 2;
                    if (r_cnt <= SQ_LAST) begin
                        r_k  <= k_next;
                        r_sd <= r_sd << 1;
                    end
                    if (r_cnt == ROOT_LAST) begin
                        r_cnt  <= '0;
                        r_num  <= {1'b0, r_k, 16'd0};
                        r_dvs  <= r_d2;
                        r_rem  <= '0;
                        r_q    <= '0;
                        r_qo   <= 1'b0;
                        r_tdiv <= 1'b0;
                        r_axis <= 1'b0;
                    end
                end
                S_DIV: begin
                    r_rem <= d_ge ? rdiff[D2_W-1:0] : rem2[D2_W-1:0];
                    r_q   <= {r_q[F_W-2:0], d_ge};
                    r_qo  <= r_qo | r_q[F_W-1];
                    r_num <= r_num << 1;
                end
                S_DIVEND: begin
                    r_cnt <= '0;
                    r_num <= '0;
                    if (!r_tdiv) begin
                        r_f  <= r_qo ? {F_W{1'b1}} : r_q;
                        r_sa <= r_adx;
                    end else begin
                        if (r_axis) begin
                            r_sum_y <= acc_lim[SUM_W-1:0];
                        end else begin
                            r_sum_x <= acc_lim[SUM_W-1:0];
                        end
                        r_clip <= r_clip | acc_clip;
                        r_axis <= 1'b1;
                        r_sa   <= r_ady;
                    end
                end
                S_AMUL: begin
                    r_num <= mul_next;
                    r_sa  <= r_sa << 1;
                    if (r_cnt == MUL_LAST) begin
                        r_cnt  <= '0;
                        r_dvs  <= {32'd0, r_root};
                        r_rem  <= '0;
                        r_q    <= '0;
                        r_qo   <= 1'b0;
                        r_tdiv <= 1'b1;
                    end
                end
                default: ;
            endcase
            if (emit) begin
                r_m_valid <= 1'b1;
                r_m_data  <= {r_sum_y, r_sum_x};
                r_m_user  <= r_clip;
                r_sum_x   <= '0;
                r_sum_y   <= '0;
                r_clip    <= 1'b0;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_dvs))
        else $error("division remainder not below divisor");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (o_m_tvalid && (r_sum_x == '0) && (r_sum_y == '0) && !r_clip))
        else $error("result not shown or sums not cleared");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) && r_last && !out_free) |=> (r_state == S_FIN))
        else $error("left finish with result pending");

    a_root_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AMUL) |-> (r_root != '0))
        else $error("zero distance reached force path");

endmodule

// ===== tb/sv/gravity_force_accumulator_core_tb.sv =====
`timescale 1ns / 1ps
module gravity_force_accumulator_core_tb;
    import gfa_pkg::*;

    localparam longint CYCLE_LIMIT = 10000000;
    localparam longint ACC_MAX = 64'sd140737488355327;
    localparam longint ACC_MIN = -64'sd140737488355328;
    localparam logic [127:0] F_CAP = (128'd1 << 80) - 128'd1;
    localparam logic [127:0] TERM_CAP = 128'd1 << 48;

    typedef struct packed {
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] mass;
        logic        body;
        logic [31:0] sr;
        logic [31:0] tx;
        logic [31:0] ty;
        logic [31:0] tr;
        logic        last;
    } t_interaction;

    typedef struct packed {
        logic [47:0] ax;
        logic [47:0] ay;
        logic        sat;
    } t_accel;

    typedef struct packed {
        t_interaction it;
        logic         typed;
        t_accel       want;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_wr_en = 1'b0;
    logic         i_cfg_addr = REG_GRAVITY;
    logic [31:0]  i_cfg_wr_data = '0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [223:0] i_s_tdata = '0;
    logic         i_s_tuser = 1'b0;
    logic         i_s_tlast = 1'b0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [95:0]  o_m_tdata;
    logic         o_m_tuser;

    gravity_force_accumulator_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_s_tlast    (i_s_tlast),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .o_m_tuser    (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [31:0] gravity_q;
    logic [31:0] tstep_q;
    longint      acc_x;
    longint      acc_y;
    bit          acc_clip;
    t_accel      accel_fifo[$];
    t_row        rows[$];
    int          fail_cnt = 0;
    longint      cycle_cnt = 0;
    bit          no_idle = 1'b0;
    int          sink_hold = 0;

    function automatic logic [127:0] axis_mag(logic [127:0] f, logic [32:0] off,
                                              logic [33:0] dr);
        logic [127:0] p;
        p = ((f * 128'(off)) / 128'(dr)) >> 8;
        return (p > TERM_CAP) ? TERM_CAP : p;
    endfunction

    function automatic void add_clamped(ref longint acc, input logic [127:0] mag,
                                        input bit neg);
        longint s;
        s = neg ? acc - longint'(mag) : acc + longint'(mag);
        if (s > ACC_MAX) begin
            s = ACC_MAX;
            acc_clip = 1'b1;
        end
        if (s < ACC_MIN) begin
            s = ACC_MIN;
            acc_clip = 1'b1;
        end
        acc = s;
    endfunction

    function automatic bit apply_interaction(t_interaction it, output t_accel res);
        logic signed [32:0] dx, dy;
        logic [32:0]  adx, ady, rsum;
        logic [65:0]  d2;
        logic [33:0]  dr, trial;
        logic [127:0] f;
        dx = {it.sx[31], it.sx} - {it.tx[31], it.tx};
        dy = {it.sy[31], it.sy} - {it.ty[31], it.ty};
        adx = dx[32] ? -dx : dx;
        ady = dy[32] ? -dy : dy;
        d2 = 66'(adx) * 66'(adx) + 66'(ady) * 66'(ady);
        rsum = 33'(it.sr) + 33'(it.tr);
        if (d2 != 0 && !(it.body && 66'(rsum) * 66'(rsum) >= d2)) begin
            dr = '0;
            for (int b = 33; b >= 0; b--) begin
                trial = dr | (34'd1 << b);
                if (68'(trial) * 68'(trial) <= 68'(d2)) dr = trial;
            end
            f = ((128'(it.mass) * 128'(gravity_q) * 128'(tstep_q)) << 16) / 128'(d2);
            if (f > F_CAP) f = F_CAP;
            add_clamped(acc_x, axis_mag(f, adx, dr), dx[32]);
            add_clamped(acc_y, axis_mag(f, ady, dr), dy[32]);
        end
        res.ax = acc_x[47:0];
        res.ay = acc_y[47:0];
        res.sat = acc_clip;
        if (!it.last) return 1'b0;
        acc_x = 0;
        acc_y = 0;
        acc_clip = 1'b0;
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(20, 200);
    endfunction

    function automatic logic [31:0] near(logic [31:0] base, int span);
        return base + 32'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic t_interaction random_interaction();
        t_interaction it;
        int mode;
        mode = $urandom_range(0, 99);
        it.sx = $urandom();
        it.sy = $urandom();
        it.mass = $urandom();
        it.body = $urandom_range(0, 1);
        it.sr = $urandom();
        it.tx = $urandom();
        it.ty = $urandom();
        it.tr = $urandom();
        it.last = ($urandom_range(0, 3) == 0);
        if (mode < 75) begin
            it.tx = near(32'h0, 1 << 22);
            it.ty = near(32'h0, 1 << 22);
            it.sx = near(it.tx, $urandom_range(1, 1 << $urandom_range(4, 22)));
            it.sy = near(it.ty, $urandom_range(1, 1 << $urandom_range(4, 22)));
            it.mass = $urandom_range(0, 1 << $urandom_range(8, 26));
            it.sr = $urandom_range(0, 1 << $urandom_range(4, 17));
            it.tr = $urandom_range(0, 1 << $urandom_range(4, 17));
            if (mode < 15) begin
                it.body = 1'b1;
                it.sr = '0;
            end
        end else if (mode < 82) begin
            it.sx = it.tx;
            it.sy = it.ty;
        end else if (mode < 88) begin
            it.body = 1'b1;
            it.sx = near(it.tx, 1 << 16);
            it.sy = near(it.ty, 1 << 16);
            it.sr = 32'h0002_0000 + $urandom_range(0, 1 << 16);
        end else if (mode < 92) begin
            it.body = 1'b0;
            it.sx = near(it.tx, 4);
            it.sy = near(it.ty, 4);
        end
        return it;
    endfunction

    task automatic write_reg(logic addr, logic [31:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (addr == REG_GRAVITY) gravity_q = value;
        else tstep_q = value;
    endtask

    task automatic send_item(t_interaction it, bit typed, t_accel want);
        t_accel res;
        int gap;
        i_s_tdata <= {it.tr, it.ty, it.tx, it.sr, it.mass, it.sy, it.sx};
        i_s_tuser <= it.body;
        i_s_tlast <= it.last;
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (apply_interaction(it, res)) begin
            accel_fifo.insert(accel_fifo.size(), typed ? want : res);
        end
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        @(posedge i_clk);
        i_s_tvalid <= 1'b0;
        while (accel_fifo.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
    endtask

    task automatic add_row(logic [31:0] sx, logic [31:0] sy, logic [31:0] mass,
                           logic body, logic [31:0] sr, logic [31:0] tx,
                           logic [31:0] ty, logic [31:0] tr, logic last,
                           logic typed, logic [47:0] ax, logic [47:0] ay, logic sat);
        t_row r;
        r.it = '{sx, sy, mass, body, sr, tx, ty, tr, last};
        r.typed = typed;
        r.want = '{ax, ay, sat};
        rows.insert(rows.size(), r);
    endtask

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_accel exp_r;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (accel_fifo.size() == 0) begin
                $display("%0t: unexpected result ax=%h ay=%h sat=%b", $time,
                         o_m_tdata[47:0], o_m_tdata[95:48], o_m_tuser);
                fail_cnt++;
            end else begin
                exp_r = accel_fifo.pop_front();
                if (o_m_tdata[47:0] !== exp_r.ax) begin
                    $display("%0t: accel_x expected %h actual %h", $time, exp_r.ax,
                             o_m_tdata[47:0]);
                    fail_cnt++;
                end
                if (o_m_tdata[95:48] !== exp_r.ay) begin
                    $display("%0t: accel_y expected %h actual %h", $time, exp_r.ay,
                             o_m_tdata[95:48]);
                    fail_cnt++;
                end
                if (o_m_tuser !== exp_r.sat) begin
                    $display("%0t: saturated expected %b actual %b", $time, exp_r.sat,
                             o_m_tuser);
                    fail_cnt++;
                end
            end
        end
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            i_m_tready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 99) < 30) begin
            sink_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300)
                                                     : $urandom_range(0, 3);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    initial begin
        logic [31:0] gset[6];
        logic [31:0] tset[6];
        t_accel none;
        none = '0;
        gravity_q = GRAVITY_RESET;
        tstep_q = TSTEP_RESET;
        acc_x = 0;
        acc_y = 0;
        acc_clip = 1'b0;
        gset = '{32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_4000,
                 32'h0003_0000, 32'h0000_0001};
        tset = '{32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_8000, 32'h0000_0000,
                 32'h0000_0100, 32'h0002_0000};

        add_row(32'h0001_0000, 0, 32'h0001_0000, 0, 0, 0, 0, 0, 1,
                1, 48'h00_0100_0000, 48'h0, 0);
        add_row(0, 32'hFFFF_0000, 32'h0001_0000, 1, 0, 0, 0, 0, 1,
                1, 48'h0, 48'hFFFF_FF00_0000, 0);
        add_row(32'h1234_5678, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0,
                32'h1234_5678, 32'h8000_0000, 0, 1, 1, 48'h0, 48'h0, 0);
        add_row(32'h0001_0000, 0, 32'h0001_0000, 1, 32'h0001_0000, 0, 0,
                32'h0001_0000, 1, 1, 48'h0, 48'h0, 0);
        add_row(32'h0001_0000, 0, 32'h0001_0000, 0, 32'h0001_0000, 0, 0,
                32'h0001_0000, 1, 0, 0, 0, 0);
        add_row(32'h0000_0001, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 1,
                1, 48'h7F_FFFF_FFFF_FF, 48'h0, 1);
        add_row(32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 1, 0, 0, 0, 0, 1,
                1, 48'h80_0000_0000_00, 48'h0, 1);
        add_row(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF,
                32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
        add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 0, 0,
                32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 0, 0);
        add_row(32'h0000_0003, 32'hFFFF_FFFD, 32'h0000_0001, 1, 32'hFFFF_FFFF, 0, 0,
                32'hFFFF_FFFF, 0, 0, 0, 0, 0);
        add_row(32'h0005_0000, 32'hFFFD_0000, 32'h0040_0000, 1, 0,
                32'hFFFF_0000, 32'h0002_0000, 32'h0000_8000, 1, 0, 0, 0, 0);
        add_row(32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0,
                0, 0, 0, 0);
        add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 1,
                0, 0, 0, 0);
        add_row(32'h0100_0000, 32'h0100_0000, 32'h0001_0000, 0, 0, 0, 0, 0, 1,
                0, 0, 0, 0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].want);
        drain();

        for (int p = 0; p < 12; p++) begin
            write_reg(REG_GRAVITY, (p < 6) ? gset[p] : $urandom_range(0, 1 << 18));
            write_reg(REG_TSTEP, (p < 6) ? tset[(p + 2) % 6] : $urandom());
            no_idle = (p % 4 == 3);
            for (int n = 0; n < 140; n++) send_item(random_interaction(), 1'b0, none);
            drain();
        end

        if (fail_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
